[rtl/mlhi_pkg.sv]
package mlhi_pkg;

    localparam int RATE_W = 11;
    localparam int CFG_IDX_W = 3;

    typedef logic [RATE_W-1:0] rate_t;

    typedef enum logic [1:0] {
        KIND_RA_LIMIT  = 2'd0,
        KIND_DEC_LIMIT = 2'd1,
        KIND_HANDSET   = 2'd2,
        KIND_MODE      = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INITIAL_RATE = 3'd0,
        REG_FINE_RATE    = 3'd1,
        REG_COARSE_RATE  = 3'd2,
        REG_SLEW_RATE    = 3'd3
    } cfg_reg_t;

    // Axis drive state, one bit each.
    typedef struct packed {
        logic dec_south;
        logic dec_run;
        logic ra_west;
        logic ra_run;
    } drive_t;

    // Switch positions inside the 4-bit limit and handset groups.
    localparam int SW_EAST  = 0;
    localparam int SW_WEST  = 1;
    localparam int SW_NORTH = 2;
    localparam int SW_SOUTH = 3;

    localparam logic [3:0] RA_LIMIT_MASK  = 4'b0011;
    localparam logic [3:0] DEC_LIMIT_MASK = 4'b1100;

    localparam rate_t INITIAL_RATE_RST = rate_t'(800);
    localparam rate_t FINE_RATE_RST    = rate_t'(800);
    localparam rate_t COARSE_RATE_RST  = rate_t'(1100);
    localparam rate_t SLEW_RATE_RST    = rate_t'(30);

endpackage

[rtl/mount_limit_and_handset_interlock_core.sv]
// Latency: a result is valid the cycle after its notice beat is accepted.
// Throughput: one notice per cycle; the drive state registers double as the
// result register, so a new beat is taken whenever the result slot is empty
// or its beat is being taken in the same cycle.
// Reset (rst_n low, asynchronous): both axes stopped, rates zero, no limits
// latched, handset disabled, handset rate and the rate registers at defaults.
module mount_limit_and_handset_interlock_core (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [1:0]                      kind,
    input  logic [15:0]                     switch_word,
    input  logic                            console_active,

    output logic                            out_valid,
    input  logic                            out_stall,
    output logic                            ra_run,
    output logic                            ra_west,
    output logic [mlhi_pkg::RATE_W-1:0]     ra_rate,
    output logic                            dec_run,
    output logic                            dec_south,
    output logic [mlhi_pkg::RATE_W-1:0]     dec_rate,
    output logic [3:0]                      limit_flags,
    output logic                            handset_on,
    output logic [mlhi_pkg::RATE_W-1:0]     handset_rate,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [mlhi_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mlhi_pkg::RATE_W-1:0]     cfg_data
);

    mlhi_pkg::rate_t  fine_rate_reg;
    mlhi_pkg::rate_t  coarse_rate_reg;
    mlhi_pkg::rate_t  slew_rate_reg;

    logic [3:0]       prev_limit_reg,  prev_limit_next;
    logic [3:0]       prev_button_reg, prev_button_next;
    logic [1:0]       prev_mode_reg,   prev_mode_next;
    logic [3:0]       latch_reg,       latch_next;
    mlhi_pkg::drive_t drive_reg,       drive_next;
    mlhi_pkg::rate_t  ra_rate_reg,     ra_rate_next;
    mlhi_pkg::rate_t  dec_rate_reg,    dec_rate_next;
    mlhi_pkg::rate_t  hand_rate_reg,   hand_rate_next;
    logic             hand_en_reg,     hand_en_next;
    logic             out_valid_reg;

    logic             in_accept;
    logic             cfg_accept;
    logic [3:0]       lim_now, lim_act, btn_now, btn_chg;
    logic [1:0]       mode_now, mode_chg;

    assign in_stall   = out_valid_reg && out_stall;
    assign in_accept  = in_valid && !in_stall;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    assign lim_now  = switch_word[3:0];
    assign btn_now  = switch_word[11:8];
    assign mode_now = switch_word[5:4];
    assign btn_chg  = btn_now ^ prev_button_reg;
    assign mode_chg = mode_now ^ prev_mode_reg;
    assign lim_act  = (lim_now ^ prev_limit_reg) &
                      ((mlhi_pkg::kind_t'(kind) == mlhi_pkg::KIND_RA_LIMIT)
                       ? mlhi_pkg::RA_LIMIT_MASK : mlhi_pkg::DEC_LIMIT_MASK);

    always_comb
    begin
        prev_limit_next  = prev_limit_reg;
        prev_button_next = prev_button_reg;
        prev_mode_next   = prev_mode_reg;
        latch_next       = latch_reg;
        drive_next       = drive_reg;
        ra_rate_next     = ra_rate_reg;
        dec_rate_next    = dec_rate_reg;
        hand_rate_next   = hand_rate_reg;
        hand_en_next     = hand_en_reg;

        unique case (mlhi_pkg::kind_t'(kind))
            mlhi_pkg::KIND_RA_LIMIT, mlhi_pkg::KIND_DEC_LIMIT:
            begin
                // Both limit kinds record all four bits; only their own pair acts.
                latch_next = (latch_reg & ~(lim_act & lim_now)) | (lim_act & ~lim_now);
                if ((lim_act & ~lim_now) != 4'd0)
                begin
                    drive_next.ra_run  = 1'b0;
                    drive_next.dec_run = 1'b0;
                end
                prev_limit_next = lim_now;
            end
            mlhi_pkg::KIND_HANDSET:
            begin
                if (hand_en_reg)
                begin
                    for (int b = 0; b < 4; b++)
                    begin
                        if (btn_chg[b])
                        begin
                            if (btn_now[b])
                            begin
                                if (b < 2) drive_next.ra_run  = 1'b0;
                                else       drive_next.dec_run = 1'b0;
                            end
                            else if (!latch_reg[b])
                            begin
                                if (b < 2)
                                begin
                                    drive_next.ra_west = (b == mlhi_pkg::SW_WEST);
                                    drive_next.ra_run  = 1'b1;
                                    ra_rate_next       = hand_rate_reg;
                                end
                                else
                                begin
                                    drive_next.dec_south = (b == mlhi_pkg::SW_SOUTH);
                                    drive_next.dec_run   = 1'b1;
                                    dec_rate_next        = hand_rate_reg;
                                end
                            end
                        end
                    end
                    prev_button_next = btn_now;
                end
            end
            mlhi_pkg::KIND_MODE:
            begin
                if (mode_chg[0])
                begin
                    if (mode_now[0])
                    begin
                        hand_rate_next = fine_rate_reg;
                    end
                    else
                    begin
                        hand_rate_next     = coarse_rate_reg;
                        drive_next.ra_run  = 1'b0;
                        drive_next.dec_run = 1'b0;
                    end
                end
                if (mode_chg[1])
                begin
                    if (mode_now[1])
                    begin
                        hand_rate_next     = fine_rate_reg;
                        drive_next.ra_run  = 1'b0;
                        drive_next.dec_run = 1'b0;
                        hand_en_next       = !console_active;
                    end
                    else if (hand_en_reg)
                    begin
                        // West slew, blocked by the west limit.
                        if (!latch_reg[mlhi_pkg::SW_WEST])
                        begin
                            drive_next.ra_west = 1'b1;
                            drive_next.ra_run  = 1'b1;
                            drive_next.dec_run = 1'b0;
                            ra_rate_next       = slew_rate_reg;
                        end
                        hand_en_next = 1'b0;
                    end
                end
                prev_mode_next = mode_now;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fine_rate_reg   <= mlhi_pkg::FINE_RATE_RST;
            coarse_rate_reg <= mlhi_pkg::COARSE_RATE_RST;
            slew_rate_reg   <= mlhi_pkg::SLEW_RATE_RST;
            prev_limit_reg  <= 4'd0;
            prev_button_reg <= 4'd0;
            prev_mode_reg   <= 2'd0;
            latch_reg       <= 4'd0;
            drive_reg       <= '0;
            ra_rate_reg     <= '0;
            dec_rate_reg    <= '0;
            hand_rate_reg   <= mlhi_pkg::INITIAL_RATE_RST;
            hand_en_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                prev_limit_reg  <= prev_limit_next;
                prev_button_reg <= prev_button_next;
                prev_mode_reg   <= prev_mode_next;
                latch_reg       <= latch_next;
                drive_reg       <= drive_next;
                ra_rate_reg     <= ra_rate_next;
                dec_rate_reg    <= dec_rate_next;
                hand_en_reg     <= hand_en_next;
                out_valid_reg   <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            // Writing the initial rate presets the handset rate at once.
            if (cfg_accept && cfg_index == mlhi_pkg::REG_INITIAL_RATE)
            begin
                hand_rate_reg <= cfg_data;
            end
            else if (in_accept)
            begin
                hand_rate_reg <= hand_rate_next;
            end

            if (cfg_accept)
            begin
                unique case (cfg_index)
                    mlhi_pkg::REG_INITIAL_RATE:
                    begin
                    end
                    mlhi_pkg::REG_FINE_RATE:    fine_rate_reg   <= cfg_data;
                    mlhi_pkg::REG_COARSE_RATE:  coarse_rate_reg <= cfg_data;
                    mlhi_pkg::REG_SLEW_RATE:    slew_rate_reg   <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign ra_run       = drive_reg.ra_run;
    assign ra_west      = drive_reg.ra_west;
    assign ra_rate      = ra_rate_reg;
    assign dec_run      = drive_reg.dec_run;
    assign dec_south    = drive_reg.dec_south;
    assign dec_rate     = dec_rate_reg;
    assign limit_flags  = latch_reg;
    assign handset_on   = hand_en_reg;
    assign handset_rate = hand_rate_reg;

    // A beat taken always leaves a result waiting next cycle.
    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted notice produced no result");

    // A newly latched limit means both axes are stopped.
    a_limit_stops: assert property (@(posedge clk) disable iff (!rst_n)
        ((latch_reg & ~$past(latch_reg)) != 4'd0) |-> (!drive_reg.ra_run && !drive_reg.dec_run))
        else $error("limit latched while an axis runs");

    // Handset enable only comes from a mode notice.
    a_enable_from_mode: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(hand_en_reg) |-> $past(in_accept && kind == mlhi_pkg::KIND_MODE))
        else $error("handset enabled without a mode notice");

    // Drive state only moves on an accepted notice.
    a_drive_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !in_accept |=> $stable(drive_reg) && $stable(latch_reg))
        else $error("drive state changed without a notice");

endmodule

[verif/mount_limit_and_handset_interlock_core_tb.sv]
module mount_limit_and_handset_interlock_core_tb;

    import mlhi_pkg::*;

    typedef struct packed {
        logic       ra_run;
        logic       ra_west;
        rate_t      ra_rate;
        logic       dec_run;
        logic       dec_south;
        rate_t      dec_rate;
        logic [3:0] flags;
        logic       hand_on;
        rate_t      hand_rate;
    } result_t;

    typedef struct {
        kind_t       k;
        logic [15:0] w;
        logic        c;
        bit          typed;
        result_t     want;
    } notice_row_t;

    localparam int ITEMS_PER_PHASE = 138;
    localparam int NUM_PHASES      = 6;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [1:0]            kind = KIND_RA_LIMIT;
    logic [15:0]           switch_word = '0;
    logic                  console_active = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  ra_run;
    logic                  ra_west;
    logic [RATE_W-1:0]     ra_rate;
    logic                  dec_run;
    logic                  dec_south;
    logic [RATE_W-1:0]     dec_rate;
    logic [3:0]            limit_flags;
    logic                  handset_on;
    logic [RATE_W-1:0]     handset_rate;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [RATE_W-1:0]     cfg_data = '0;

    // predictor state
    rate_t      cur_initial = INITIAL_RATE_RST;
    rate_t      cur_fine    = FINE_RATE_RST;
    rate_t      cur_coarse  = COARSE_RATE_RST;
    rate_t      cur_slew    = SLEW_RATE_RST;
    logic [3:0] seen_limits = '0;
    logic [3:0] seen_buttons = '0;
    logic [1:0] seen_mode = '0;
    logic [3:0] latched_limits = '0;
    drive_t     axis = '0;
    rate_t      ra_speed = '0;
    rate_t      dec_speed = '0;
    rate_t      hand_speed = INITIAL_RATE_RST;
    logic       hand_enabled = 1'b0;

    result_t    pending_drive[$];
    result_t    oldest_drive;
    int         mismatches = 0;
    bit         quiet_phase = 1'b0;
    int         stall_left = 0;
    bit         stall_now;

    mount_limit_and_handset_interlock_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .switch_word    (switch_word),
        .console_active (console_active),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .ra_run         (ra_run),
        .ra_west        (ra_west),
        .ra_rate        (ra_rate),
        .dec_run        (dec_run),
        .dec_south      (dec_south),
        .dec_rate       (dec_rate),
        .limit_flags    (limit_flags),
        .handset_on     (handset_on),
        .handset_rate   (handset_rate),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("FAIL mount_limit_and_handset_interlock_core");
        $finish;
    end

    function automatic result_t mk_result(int rr, int rw, int rrate, int dr, int ds, int drate,
                                          int fl, int on, int hr);
        result_t r;
        r.ra_run    = 1'(rr);
        r.ra_west   = 1'(rw);
        r.ra_rate   = rate_t'(rrate);
        r.dec_run   = 1'(dr);
        r.dec_south = 1'(ds);
        r.dec_rate  = rate_t'(drate);
        r.flags     = 4'(fl);
        r.hand_on   = 1'(on);
        r.hand_rate = rate_t'(hr);
        return r;
    endfunction

    function automatic result_t drive_snapshot();
        result_t r;
        r.ra_run    = axis.ra_run;
        r.ra_west   = axis.ra_west;
        r.ra_rate   = ra_speed;
        r.dec_run   = axis.dec_run;
        r.dec_south = axis.dec_south;
        r.dec_rate  = dec_speed;
        r.flags     = latched_limits;
        r.hand_on   = hand_enabled;
        r.hand_rate = hand_speed;
        return r;
    endfunction

    function automatic void apply_notice(kind_t k, logic [15:0] w, logic c);
        logic [3:0] now4;
        logic [3:0] diff4;
        logic [1:0] now2;
        logic [1:0] diff2;
        case (k)
            KIND_RA_LIMIT, KIND_DEC_LIMIT:
            begin
                now4 = w[3:0];
                // all four bits are recorded, only this axis' pair is acted on
                diff4 = (now4 ^ seen_limits) &
                        ((k == KIND_RA_LIMIT) ? RA_LIMIT_MASK : DEC_LIMIT_MASK);
                for (int b = SW_EAST; b <= SW_SOUTH; b++)
                begin
                    if (diff4[b])
                    begin
                        if (now4[b])
                            latched_limits[b] = 1'b0;
                        else
                        begin
                            axis.ra_run  = 1'b0;
                            axis.dec_run = 1'b0;
                            latched_limits[b] = 1'b1;
                        end
                    end
                end
                seen_limits = now4;
            end
            KIND_HANDSET:
            begin
                if (hand_enabled)
                begin
                    now4  = w[11:8];
                    diff4 = now4 ^ seen_buttons;
                    for (int b = SW_EAST; b <= SW_SOUTH; b++)
                    begin
                        if (diff4[b])
                        begin
                            if (b < SW_NORTH)
                            begin
                                if (now4[b])
                                    axis.ra_run = 1'b0;
                                else if (!latched_limits[b])
                                begin
                                    axis.ra_west = (b == SW_WEST);
                                    ra_speed     = hand_speed;
                                    axis.ra_run  = 1'b1;
                                end
                            end
                            else
                            begin
                                if (now4[b])
                                    axis.dec_run = 1'b0;
                                else if (!latched_limits[b])
                                begin
                                    axis.dec_south = (b == SW_SOUTH);
                                    dec_speed      = hand_speed;
                                    axis.dec_run   = 1'b1;
                                end
                            end
                        end
                    end
                    seen_buttons = now4;
                end
            end
            default:
            begin
                now2  = w[5:4];
                diff2 = now2 ^ seen_mode;
                if (diff2[0])
                begin
                    if (now2[0])
                        hand_speed = cur_fine;
                    else
                    begin
                        hand_speed   = cur_coarse;
                        axis.ra_run  = 1'b0;
                        axis.dec_run = 1'b0;
                    end
                end
                if (diff2[1])
                begin
                    if (now2[1])
                    begin
                        hand_speed   = cur_fine;
                        axis.ra_run  = 1'b0;
                        axis.dec_run = 1'b0;
                        hand_enabled = !c;
                    end
                    else if (hand_enabled)
                    begin
                        // west slew, blocked by a latched west limit
                        if (!latched_limits[SW_WEST])
                        begin
                            axis.ra_west = 1'b1;
                            ra_speed     = cur_slew;
                            axis.ra_run  = 1'b1;
                            axis.dec_run = 1'b0;
                        end
                        hand_enabled = 1'b0;
                    end
                end
                seen_mode = now2;
            end
        endcase
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t %s: expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    task automatic send_notice(kind_t k, logic [15:0] w, logic c, bit typed, result_t want);
        int gap;
        gap = quiet_phase ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        kind           <= k;
        switch_word    <= w;
        console_active <= c;
        do @(posedge clk); while (in_stall);
        apply_notice(k, w, c);
        pending_drive.push_back(typed ? want : drive_snapshot());
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_drive.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, rate_t val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_INITIAL_RATE:
            begin
                cur_initial = val;
                hand_speed  = val;
            end
            REG_FINE_RATE:   cur_fine   = val;
            REG_COARSE_RATE: cur_coarse = val;
            REG_SLEW_RATE:   cur_slew   = val;
            default: ;
        endcase
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_drive.size() == 0)
            begin
                mismatches++;
                $display("%0t result beat with nothing expected", $time);
            end
            else
            begin
                oldest_drive = pending_drive.pop_front();
                check_field("ra_run",       32'(oldest_drive.ra_run),    32'(ra_run));
                check_field("ra_west",      32'(oldest_drive.ra_west),   32'(ra_west));
                check_field("ra_rate",      32'(oldest_drive.ra_rate),   32'(ra_rate));
                check_field("dec_run",      32'(oldest_drive.dec_run),   32'(dec_run));
                check_field("dec_south",    32'(oldest_drive.dec_south), 32'(dec_south));
                check_field("dec_rate",     32'(oldest_drive.dec_rate),  32'(dec_rate));
                check_field("limit_flags",  32'(oldest_drive.flags),     32'(limit_flags));
                check_field("handset_on",   32'(oldest_drive.hand_on),   32'(handset_on));
                check_field("handset_rate", 32'(oldest_drive.hand_rate), 32'(handset_rate));
            end
        end

        if (!rst_n || quiet_phase)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
            stall_left--;
        else
        begin
            stall_now = ($urandom_range(0, 2) == 0);
            out_stall <= stall_now;
            stall_left = stall_now ? pick_gap() : $urandom_range(0, 8);
        end
    end

    initial
    begin
        notice_row_t dir_tab[$];
        logic [3:0]  img_limits;
        logic [3:0]  img_buttons;
        logic [1:0]  img_mode;
        kind_t       k;
        logic [15:0] w;
        logic        c;
        int          r;
        rate_t       vals[4];

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        dir_tab = '{
            '{KIND_RA_LIMIT,  16'h0000, 1'b0, 1'b1, mk_result(0, 0, 0, 0, 0, 0, 0, 0, 800)},
            '{KIND_RA_LIMIT,  16'hFFFF, 1'b1, 1'b1, mk_result(0, 0, 0, 0, 0, 0, 0, 0, 800)},
            '{KIND_DEC_LIMIT, 16'hFFFF, 1'b0, 1'b0, '0},
            // north limit closes
            '{KIND_DEC_LIMIT, 16'hFFFB, 1'b0, 1'b1, mk_result(0, 0, 0, 0, 0, 0, 4, 0, 800)},
            // handset still disabled
            '{KIND_HANDSET,   16'h0000, 1'b0, 1'b0, '0},
            '{KIND_MODE,      16'hFFFF, 1'b0, 1'b1, mk_result(0, 0, 0, 0, 0, 0, 4, 1, 800)},
            '{KIND_HANDSET,   16'hFFFF, 1'b0, 1'b0, '0},
            '{KIND_HANDSET,   16'hFEFF, 1'b0, 1'b1, mk_result(1, 0, 800, 0, 0, 0, 4, 1, 800)},
            // east release, north press blocked by its limit
            '{KIND_HANDSET,   16'hFBFF, 1'b0, 1'b0, '0},
            '{KIND_HANDSET,   16'hF7FF, 1'b0, 1'b0, '0},
            '{KIND_MODE,      16'hFFEF, 1'b0, 1'b0, '0},
            '{KIND_HANDSET,   16'hFDFF, 1'b0, 1'b0, '0},
            // west slew at slew rate, handset drops out
            '{KIND_MODE,      16'hFFDF, 1'b0, 1'b1, mk_result(1, 1, 30, 0, 1, 800, 4, 0, 800)},
            '{KIND_DEC_LIMIT, 16'hFFFF, 1'b0, 1'b0, '0},
            '{KIND_RA_LIMIT,  16'hFFFD, 1'b0, 1'b0, '0},
            '{KIND_MODE,      16'hFFFF, 1'b1, 1'b0, '0},
            '{KIND_MODE,      16'hFFDF, 1'b0, 1'b0, '0},
            '{KIND_MODE,      16'hFFFF, 1'b0, 1'b0, '0},
            // slew refused with west limit latched
            '{KIND_MODE,      16'hFFDF, 1'b0, 1'b0, '0},
            '{KIND_RA_LIMIT,  16'h0000, 1'b1, 1'b0, '0},
            // DEC bits already recorded by the RA notice
            '{KIND_DEC_LIMIT, 16'h0000, 1'b0, 1'b0, '0},
            '{KIND_DEC_LIMIT, 16'hFFFF, 1'b0, 1'b0, '0},
            '{KIND_RA_LIMIT,  16'hFFFF, 1'b0, 1'b0, '0}
        };

        foreach (dir_tab[i])
            send_notice(dir_tab[i].k, dir_tab[i].w, dir_tab[i].c,
                        dir_tab[i].typed, dir_tab[i].want);

        img_limits  = 4'hF;
        img_buttons = 4'hF;
        img_mode    = 2'b11;

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_results();
            quiet_phase = (p == 2);
            if (p > 0)
            begin
                case (p)
                    1: vals = '{default: rate_t'(0)};
                    2: vals = '{default: rate_t'(2047)};
                    default:
                        foreach (vals[j])
                            vals[j] = rate_t'($urandom_range(0, 2047));
                endcase
                write_reg(REG_FINE_RATE,    vals[1]);
                write_reg(REG_SLEW_RATE,    vals[3]);
                write_reg(REG_INITIAL_RATE, vals[0]);
                write_reg(REG_COARSE_RATE,  vals[2]);
                // unused index, must be ignored
                write_reg(CFG_IDX_W'(REG_SLEW_RATE) + CFG_IDX_W'($urandom_range(1, 4)),
                          rate_t'((p == 1) ? 2047 : $urandom_range(0, 2047)));
                cfg_valid <= 1'b0;
            end

            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                r = $urandom_range(0, 99);
                w = 16'($urandom);
                c = ($urandom_range(0, 6) == 0);
                if (r < 8)
                begin
                    // noise beat
                    k = kind_t'($urandom_range(0, 3));
                    c = 1'($urandom_range(0, 1));
                end
                else if (r < 20)
                begin
                    k = KIND_RA_LIMIT;
                    if ($urandom_range(0, 9) == 0)
                        img_limits[$urandom_range(0, 3)] ^= 1'b1;
                    else
                        img_limits[$urandom_range(SW_EAST, SW_WEST)] ^= 1'b1;
                    w[3:0] = img_limits;
                end
                else if (r < 32)
                begin
                    k = KIND_DEC_LIMIT;
                    if ($urandom_range(0, 9) == 0)
                        img_limits[$urandom_range(0, 3)] ^= 1'b1;
                    else
                        img_limits[$urandom_range(SW_NORTH, SW_SOUTH)] ^= 1'b1;
                    w[3:0] = img_limits;
                end
                else if (r < 78)
                begin
                    k = KIND_HANDSET;
                    img_buttons[$urandom_range(0, 3)] ^= 1'b1;
                    if ($urandom_range(0, 4) == 0)
                        img_buttons[$urandom_range(0, 3)] ^= 1'b1;
                    w[11:8] = img_buttons;
                end
                else
                begin
                    k = KIND_MODE;
                    r = $urandom_range(0, 9);
                    if (r < 4)
                        img_mode[0] ^= 1'b1;
                    else if (r < 9)
                        img_mode[1] ^= 1'b1;
                    else
                        img_mode ^= 2'b11;
                    w[5:4] = img_mode;
                end
                case (k)
                    KIND_RA_LIMIT, KIND_DEC_LIMIT: img_limits = w[3:0];
                    KIND_HANDSET:                  img_buttons = w[11:8];
                    default:                       img_mode = w[5:4];
                endcase
                send_notice(k, w, c, 1'b0, '0);
            end
        end

        drain_results();
        quiet_phase = 1'b0;
        if (mismatches == 0 && pending_drive.size() == 0)
            $display("PASS mount_limit_and_handset_interlock_core");
        else
            $display("FAIL mount_limit_and_handset_interlock_core");
        $finish;
    end

endmodule
